// ----- rtl/mtrv_pkg.sv -----
// Package for the Modbus TCP request validator: word types, check codes
// and protocol constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mtrv_pkg;

   // Function codes that the validator understands.
   localparam logic [7:0] FC_READ_COILS     = 8'h01;
   localparam logic [7:0] FC_READ_REGS      = 8'h03;
   localparam logic [7:0] FC_WRITE_REGS     = 8'h10;

   // Wire exception codes, one for each failing check.
   localparam logic [7:0] EXC_NONE          = 8'h00;
   localparam logic [7:0] EXC_PROTOCOL      = 8'h0C;
   localparam logic [7:0] EXC_LENGTH        = 8'h0D;
   localparam logic [7:0] EXC_UNIT          = 8'h0E;
   localparam logic [7:0] EXC_FUNCTION      = 8'h01;
   localparam logic [7:0] EXC_START         = 8'h02;
   localparam logic [7:0] EXC_QUANTITY      = 8'h03;

   localparam logic [15:0] COIL_BASE        = 16'h5555;
   localparam logic [15:0] COIL_TOP         = 16'h5595;
   localparam logic [16:0] SPAN_LIMIT       = 17'h00040;
   localparam logic [7:0]  UNIT_LIMIT       = 8'h40;
   localparam logic [7:0]  GATEWAY_UNIT     = 8'hFF;
   localparam logic [15:0] FIXED_LENGTH     = 16'd6;
   localparam logic [15:0] WRITE_OVERHEAD   = 16'd7;
   localparam logic [15:0] GATEWAY_WIDE     = 16'h0020;
   localparam logic [15:0] GATEWAY_QTY      = 16'h0008;
   localparam logic [15:0] GATEWAY_QTY_WIDE = 16'h0009;
   localparam logic [7:0]  RSP_EXCEPTION_BIT = 8'h80;

   typedef enum logic [2:0] {
      ERR_NONE     = 3'd0,
      ERR_PROTOCOL = 3'd1,
      ERR_LENGTH   = 3'd2,
      ERR_UNIT     = 3'd3,
      ERR_FUNCTION = 3'd4,
      ERR_START    = 3'd5,
      ERR_QUANTITY = 3'd6
   } error_kind_type;

   typedef struct packed {
      logic [15:0] protocol_id;
      logic [15:0] length_field;
      logic [7:0]  unit_id;
      logic [7:0]  function_code;
      logic [15:0] start_address;
      logic [15:0] quantity;
      logic [7:0]  byte_count;
   } req_word_type;

   typedef struct packed {
      logic           accepted;
      error_kind_type error_kind;
      logic [7:0]     exception_byte;
      logic [7:0]     response_function;
   } rsp_word_type;

endpackage

`default_nettype wire

// ----- rtl/modbus_tcp_request_validator_top.sv -----
// Top level of the Modbus TCP request validator: input register, header
// checks and result register. Depends on mtrv_pkg and mtrv_check.
`timescale 1ns / 1ps
`default_nettype none

// Validates one decoded Modbus TCP request header per word and returns one
// result word for it. A request word is registered on acceptance, checked
// by purely combinational logic while it sits in the input register, and
// its result is registered when the output register can advance. One word
// per cycle is sustained as long as results are taken. While a result waits
// on the output, the input register still takes one more word and then holds
// off until the result is taken; rsp_ready reaches req_ready combinationally.
module modbus_tcp_request_validator_top (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  mtrv_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output mtrv_pkg::rsp_word_type rsp_word
);

   logic                   hold_valid_ff;
   logic                   hold_valid_in;
   mtrv_pkg::req_word_type hold_word_ff;
   logic                   out_valid_ff;
   logic                   out_valid_in;
   mtrv_pkg::rsp_word_type out_word_ff;
   mtrv_pkg::rsp_word_type check_word;
   logic                   out_advance;

   mtrv_check u_check (
      .req_word (hold_word_ff),
      .rsp_word (check_word)
   );

   assign out_advance = !out_valid_ff || rsp_ready;
   assign req_ready   = !hold_valid_ff || out_advance;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (req_ready) begin
         hold_valid_in = req_valid;
      end
      out_valid_in = out_valid_ff;
      if (out_advance) begin
         out_valid_in = hold_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         hold_word_ff <= req_word;
      end
      if (out_advance && hold_valid_ff) begin
         out_word_ff <= check_word;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

`ifndef SYNTHESIS
   a_accepted_matches_kind: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_word_ff.accepted ==
                        (out_word_ff.error_kind == mtrv_pkg::ERR_NONE)))
      else $error("accepted flag disagrees with error kind");

   a_exception_zero_iff_ok: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_word_ff.accepted ==
                        (out_word_ff.exception_byte == mtrv_pkg::EXC_NONE)))
      else $error("exception byte disagrees with accepted flag");

   a_hold_kept_on_stall: assert property (@(posedge clock) disable iff (reset)
      (hold_valid_ff && !out_advance) |=> (hold_valid_ff && $stable(hold_word_ff)))
      else $error("held request lost while output stalled");

   a_accept_fills_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> hold_valid_ff)
      else $error("accepted request not held");

   a_hold_moves_to_out: assert property (@(posedge clock) disable iff (reset)
      (hold_valid_ff && out_advance) |=> out_valid_ff)
      else $error("checked request did not reach output");
`endif

endmodule

`default_nettype wire

// ----- rtl/mtrv_check.sv -----
// Header check logic of the Modbus TCP request validator: runs the six
// ordered checks on one request word. Depends on mtrv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mtrv_check (
   input  mtrv_pkg::req_word_type req_word,
   output mtrv_pkg::rsp_word_type rsp_word
);

   logic [7:0]  fc;
   logic [7:0]  unit;
   logic [15:0] start;
   logic [16:0] qty_wide;
   logic        is_coils;
   logic        is_regs;
   logic        is_write;
   logic        gateway_start;
   logic        length_ok;
   logic        unit_ok;
   logic        start_ok;
   logic        quantity_ok;
   logic [16:0] coil_span;
   logic [16:0] reg_span;
   logic [15:0] coil_offset;
   mtrv_pkg::error_kind_type kind;
   logic [7:0]  exc;

   assign fc       = req_word.function_code;
   assign unit     = req_word.unit_id;
   assign start    = req_word.start_address;
   assign qty_wide = {1'b0, req_word.quantity};
   assign is_coils = (fc == mtrv_pkg::FC_READ_COILS);
   assign is_regs  = (fc == mtrv_pkg::FC_READ_REGS);
   assign is_write = (fc == mtrv_pkg::FC_WRITE_REGS);

   assign gateway_start = (start == 16'h0000) || (start == 16'h0008) ||
                          (start == 16'h0010) || (start == 16'h0018) ||
                          (start == 16'h0020) || (start == 16'h0029);

   // Sums are one bit wider than the fields so that they never wrap.
   assign coil_offset = start - mtrv_pkg::COIL_BASE;
   assign coil_span   = {1'b0, coil_offset} + qty_wide;
   assign reg_span    = {1'b0, start} + qty_wide;

   always_comb begin
      if (is_coils || is_regs) begin
         length_ok = (req_word.length_field == mtrv_pkg::FIXED_LENGTH);
      end else if (is_write) begin
         length_ok = (req_word.length_field ==
                      ({8'h00, req_word.byte_count} + mtrv_pkg::WRITE_OVERHEAD));
      end else begin
         length_ok = 1'b1;
      end

      if (is_coils) begin
         unit_ok = (unit == mtrv_pkg::GATEWAY_UNIT);
      end else if (is_regs) begin
         unit_ok = (unit <= mtrv_pkg::UNIT_LIMIT) || (unit == mtrv_pkg::GATEWAY_UNIT);
      end else begin
         unit_ok = 1'b1;
      end

      if (is_coils) begin
         start_ok = (start >= mtrv_pkg::COIL_BASE) && (start <= mtrv_pkg::COIL_TOP) &&
                    (coil_span <= mtrv_pkg::SPAN_LIMIT);
      end else if (is_regs) begin
         start_ok = 1'b1;
         if ((unit <= mtrv_pkg::UNIT_LIMIT) &&
             (({1'b0, start} > mtrv_pkg::SPAN_LIMIT) || start[0])) begin
            start_ok = 1'b0;
         end
         if ((unit == mtrv_pkg::GATEWAY_UNIT) && !gateway_start) begin
            start_ok = 1'b0;
         end
      end else if (is_write) begin
         start_ok = ({1'b0, start} <= mtrv_pkg::SPAN_LIMIT);
      end else begin
         start_ok = 1'b1;
      end

      // A read of registers at unit exactly 0x40 has no quantity check.
      quantity_ok = 1'b1;
      if (is_coils || is_write) begin
         quantity_ok = (qty_wide <= mtrv_pkg::SPAN_LIMIT);
      end else if (is_regs) begin
         if (unit < mtrv_pkg::UNIT_LIMIT) begin
            quantity_ok = (reg_span <= mtrv_pkg::SPAN_LIMIT);
         end else if (unit == mtrv_pkg::GATEWAY_UNIT) begin
            if (start == mtrv_pkg::GATEWAY_WIDE) begin
               quantity_ok = (req_word.quantity == mtrv_pkg::GATEWAY_QTY_WIDE);
            end else if (gateway_start) begin
               quantity_ok = (req_word.quantity == mtrv_pkg::GATEWAY_QTY);
            end
         end
      end

      if (req_word.protocol_id != 16'h0000) begin
         kind = mtrv_pkg::ERR_PROTOCOL;
         exc  = mtrv_pkg::EXC_PROTOCOL;
      end else if (!length_ok) begin
         kind = mtrv_pkg::ERR_LENGTH;
         exc  = mtrv_pkg::EXC_LENGTH;
      end else if (!unit_ok) begin
         kind = mtrv_pkg::ERR_UNIT;
         exc  = mtrv_pkg::EXC_UNIT;
      end else if (!(is_coils || is_regs || is_write)) begin
         kind = mtrv_pkg::ERR_FUNCTION;
         exc  = mtrv_pkg::EXC_FUNCTION;
      end else if (!start_ok) begin
         kind = mtrv_pkg::ERR_START;
         exc  = mtrv_pkg::EXC_START;
      end else if (!quantity_ok) begin
         kind = mtrv_pkg::ERR_QUANTITY;
         exc  = mtrv_pkg::EXC_QUANTITY;
      end else begin
         kind = mtrv_pkg::ERR_NONE;
         exc  = mtrv_pkg::EXC_NONE;
      end
   end

   always_comb begin
      rsp_word.accepted       = (kind == mtrv_pkg::ERR_NONE);
      rsp_word.error_kind     = kind;
      rsp_word.exception_byte = exc;
      if (kind == mtrv_pkg::ERR_NONE) begin
         rsp_word.response_function = fc;
      end else begin
         rsp_word.response_function = fc + mtrv_pkg::RSP_EXCEPTION_BIT;
      end
   end

endmodule

`default_nettype wire
